// File: hdl/esc_pkg.sv
// Constants and helpers for the epoch-seconds to calendar conversion.
`default_nettype none

package esc_pkg;

    localparam int unsigned C_STAGES = 7;

    // The input code that marks a missing time stamp.
    localparam logic [31:0] C_INVALID_STAMP = 32'hFFFF_FFFF;

    // Seconds from 1900-03-01 00:00:00 to 1970-01-01 00:00:00 (25508 days).
    localparam logic [32:0] C_SEC_OFFSET = 33'd2203891200;

    // 86400 = 128 * 675; ceil(2^36 / 675) gives an exact quotient for 26-bit values.
    localparam logic [26:0] C_RECIP_675  = 27'd101806633;
    localparam logic [9:0]  C_DIV_675    = 10'd675;

    // ceil(2^27 / 1461) gives an exact quotient for 16-bit day counts.
    localparam logic [16:0] C_RECIP_1461 = 17'd91868;
    localparam logic [10:0] C_DAYS_4YR   = 11'd1461;

    // ceil(2^23 / 60) for 17-bit values and ceil(2^17 / 60) for 11-bit values.
    localparam logic [17:0] C_RECIP_60_SEC = 18'd139811;
    localparam logic [11:0] C_RECIP_60_MIN = 12'd2185;
    localparam logic [5:0]  C_SIXTY        = 6'd60;

    localparam logic [8:0]  C_DAYS_YEAR  = 9'd365;
    localparam logic [10:0] C_BASE_YEAR  = 11'd1900;
    localparam int unsigned C_MONTHS     = 12;

    // First day of each month within a year that starts on March 1.
    function automatic logic [8:0] f_month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/epoch_seconds_to_calendar_unit.sv
// Top level: pipelined conversion of signed Unix seconds to the UTC calendar date and time.
`default_nettype none

// Converts a signed 32-bit count of seconds since 1970-01-01 00:00:00 UTC into second,
// minute, hour, day of month, month and year (1901 to 2038). A transaction is taken at
// every clock edge where start is high; busy is always low, so one time stamp can enter
// in every cycle. A result is on the output ports for one cycle with o_strobe high, in the
// order of the inputs. The receiver cannot hold results off, so it must take every result
// in the cycle where o_strobe is high. The conversion passes through seven register stages
// of constant-reciprocal multiplies that split the count into days, four-year cycles and
// time of day. An input of all ones sets o_invalid and drives every date and time field
// to zero.
module epoch_seconds_to_calendar_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_epoch_seconds,
    output logic                    o_strobe,
    output logic                    o_invalid,
    output logic [5:0]              o_second,
    output logic [5:0]              o_minute,
    output logic [4:0]              o_hour,
    output logic [4:0]              o_day_of_month,
    output logic [3:0]              o_month,
    output logic [10:0]             o_year
);

    logic [esc_pkg::C_STAGES-1:0] r_vld;
    logic [esc_pkg::C_STAGES-1:0] n_vld;

    // Stage 1: shift the count so that zero is 1900-03-01.
    logic [32:0] r1_u, n1_u;
    logic        r1_inv, n1_inv;

    // Stage 2: reciprocal multiply for the day count.
    logic [52:0] r2_prod, n2_prod;
    logic [25:0] r2_x;
    logic [6:0]  r2_lo;
    logic        r2_inv;

    // Stage 3: day count, seconds of day, four-year cycle multiply.
    logic [15:0] r3_q, n3_q;
    logic [16:0] r3_rem, n3_rem;
    logic [32:0] r3_cprod, n3_cprod;
    logic        r3_inv;

    // Stage 4: day within the cycle, minute multiply.
    logic [5:0]  r4_c, n4_c;
    logic [10:0] r4_ry, n4_ry;
    logic [16:0] r4_rem;
    logic [34:0] r4_mprod, n4_mprod;
    logic        r4_inv;

    // Stage 5: minutes of day, second, hour multiply, year in cycle, day of year.
    logic [10:0] r5_mins, n5_mins;
    logic [5:0]  r5_sec, n5_sec;
    logic [22:0] r5_hprod, n5_hprod;
    logic [1:0]  r5_yic, n5_yic;
    logic [8:0]  r5_doy, n5_doy;
    logic [5:0]  r5_c;
    logic        r5_inv;

    // Stage 6: hour, minute, month index.
    logic [4:0]  r6_hour, n6_hour;
    logic [5:0]  r6_min, n6_min;
    logic [3:0]  r6_mp, n6_mp;
    logic [8:0]  r6_doy;
    logic [1:0]  r6_yic;
    logic [5:0]  r6_c;
    logic [5:0]  r6_sec;
    logic        r6_inv;

    // Stage 7: output registers.
    logic        r7_inv, n7_inv;
    logic [5:0]  r7_sec, n7_sec;
    logic [5:0]  r7_min, n7_min;
    logic [4:0]  r7_hour, n7_hour;
    logic [4:0]  r7_day, n7_day;
    logic [3:0]  r7_month, n7_month;
    logic [10:0] r7_year, n7_year;

    assign busy = 1'b0;

    always_comb begin
        n_vld = {r_vld[esc_pkg::C_STAGES-2:0], start};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_comb begin
        n1_u   = {i_epoch_seconds[31], i_epoch_seconds} + esc_pkg::C_SEC_OFFSET;
        n1_inv = (i_epoch_seconds == esc_pkg::C_INVALID_STAMP);
    end

    always_comb begin
        n2_prod = 53'(r1_u[32:7]) * 53'(esc_pkg::C_RECIP_675);
    end

    always_comb begin
        logic [25:0] qm;
        logic [25:0] t;
        n3_q     = r2_prod[51:36];
        qm       = 26'(n3_q) * 26'(esc_pkg::C_DIV_675);
        t        = r2_x - qm;
        n3_rem   = {t[9:0], r2_lo};
        n3_cprod = 33'(n3_q) * 33'(esc_pkg::C_RECIP_1461);
    end

    always_comb begin
        logic [15:0] cm;
        n4_c     = r3_cprod[32:27];
        cm       = 16'(n4_c) * 16'(esc_pkg::C_DAYS_4YR);
        n4_ry    = 11'(r3_q - cm);
        n4_mprod = 35'(r3_rem) * 35'(esc_pkg::C_RECIP_60_SEC);
    end

    always_comb begin
        logic [16:0] sm;
        logic [10:0] ym;
        n5_mins  = r4_mprod[33:23];
        sm       = 17'(n5_mins) * 17'(esc_pkg::C_SIXTY);
        n5_sec   = 6'(r4_rem - sm);
        n5_hprod = 23'(n5_mins) * 23'(esc_pkg::C_RECIP_60_MIN);
        if (r4_ry >= 11'(3 * esc_pkg::C_DAYS_YEAR)) begin
            n5_yic = 2'd3;
        end else if (r4_ry >= 11'(2 * esc_pkg::C_DAYS_YEAR)) begin
            n5_yic = 2'd2;
        end else if (r4_ry >= 11'(esc_pkg::C_DAYS_YEAR)) begin
            n5_yic = 2'd1;
        end else begin
            n5_yic = 2'd0;
        end
        ym     = 11'(n5_yic) * 11'(esc_pkg::C_DAYS_YEAR);
        n5_doy = 9'(r4_ry - ym);
    end

    always_comb begin
        logic [10:0] hm;
        n6_hour = r5_hprod[21:17];
        hm      = 11'(n6_hour) * 11'(esc_pkg::C_SIXTY);
        n6_min  = 6'(r5_mins - hm);
        n6_mp   = '0;
        for (int k = 1; k < esc_pkg::C_MONTHS; k++) begin
            if (r5_doy >= esc_pkg::f_month_start(4'(k))) begin
                n6_mp = n6_mp + 4'd1;
            end
        end
    end

    always_comb begin
        logic        late;
        logic [8:0]  dd;
        late = (r6_mp >= 4'd10);
        dd   = r6_doy - esc_pkg::f_month_start(r6_mp) + 9'd1;
        if (r6_inv) begin
            n7_inv   = 1'b1;
            n7_sec   = '0;
            n7_min   = '0;
            n7_hour  = '0;
            n7_day   = '0;
            n7_month = '0;
            n7_year  = '0;
        end else begin
            n7_inv   = 1'b0;
            n7_sec   = r6_sec;
            n7_min   = r6_min;
            n7_hour  = r6_hour;
            n7_day   = dd[4:0];
            n7_month = late ? (r6_mp - 4'd9) : (r6_mp + 4'd3);
            n7_year  = esc_pkg::C_BASE_YEAR + {3'b000, r6_c, 2'b00}
                       + 11'(r6_yic) + 11'(late);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_u     <= n1_u;
        r1_inv   <= n1_inv;

        r2_prod  <= n2_prod;
        r2_x     <= r1_u[32:7];
        r2_lo    <= r1_u[6:0];
        r2_inv   <= r1_inv;

        r3_q     <= n3_q;
        r3_rem   <= n3_rem;
        r3_cprod <= n3_cprod;
        r3_inv   <= r2_inv;

        r4_c     <= n4_c;
        r4_ry    <= n4_ry;
        r4_rem   <= r3_rem;
        r4_mprod <= n4_mprod;
        r4_inv   <= r3_inv;

        r5_mins  <= n5_mins;
        r5_sec   <= n5_sec;
        r5_hprod <= n5_hprod;
        r5_yic   <= n5_yic;
        r5_doy   <= n5_doy;
        r5_c     <= r4_c;
        r5_inv   <= r4_inv;

        r6_hour  <= n6_hour;
        r6_min   <= n6_min;
        r6_mp    <= n6_mp;
        r6_doy   <= r5_doy;
        r6_yic   <= r5_yic;
        r6_c     <= r5_c;
        r6_sec   <= r5_sec;
        r6_inv   <= r5_inv;

        r7_inv   <= n7_inv;
        r7_sec   <= n7_sec;
        r7_min   <= n7_min;
        r7_hour  <= n7_hour;
        r7_day   <= n7_day;
        r7_month <= n7_month;
        r7_year  <= n7_year;
    end

    assign o_strobe       = r_vld[esc_pkg::C_STAGES-1];
    assign o_invalid      = r7_inv;
    assign o_second       = r7_sec;
    assign o_minute       = r7_min;
    assign o_hour         = r7_hour;
    assign o_day_of_month = r7_day;
    assign o_month        = r7_month;
    assign o_year         = r7_year;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the epoch-seconds to calendar conversion unit.
module tb;

    localparam int unsigned C_PERIOD_HI = 6;
    localparam int unsigned C_PERIOD_LO = 6;
    localparam int unsigned C_WATCHDOG_LIMIT = 2000;
    localparam int unsigned C_DRAIN_CYCLES = 4 * esc_pkg::C_STAGES;
    localparam int unsigned C_ITEMS_PER_PHASE = 275;
    localparam int unsigned C_MAX_REPORTS = 10;

    typedef struct packed {
        logic        invalid;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [10:0] year;
    } t_calendar;

    class t_calendar_scoreboard;
        t_calendar pending_dates[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function t_calendar calendar_of(logic [31:0] stamp);
            t_calendar r;
            longint s, days, rem, z, era, doe, yoe, doy, mp, y, m;
            r = '0;
            if (stamp == esc_pkg::C_INVALID_STAMP) begin
                r.invalid = 1'b1;
                return r;
            end
            s = longint'($signed(stamp));
            days = s / 86400;
            rem = s % 86400;
            if (rem < 0) begin
                rem += 86400;
                days -= 1;
            end
            z = days + 719468;
            era = (z >= 0 ? z : z - 146096) / 146097;
            doe = z - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp = (5 * doy + 2) / 153;
            y = yoe + era * 400;
            m = (mp < 10) ? mp + 3 : mp - 9;
            r.second = 6'(rem % 60);
            r.minute = 6'((rem / 60) % 60);
            r.hour = 5'(rem / 3600);
            r.day_of_month = 5'(doy - (153 * mp + 2) / 5 + 1);
            r.month = 4'(m);
            r.year = 11'((m <= 2) ? y + 1 : y);
            return r;
        endfunction

        function void note_stamp(logic [31:0] stamp);
            pending_dates.push_back(calendar_of(stamp));
        endfunction

        function void report(string what, t_calendar exp_d, t_calendar got_d);
            mismatches++;
            if (mismatches <= C_MAX_REPORTS) begin
                $write("%s: expected inv=%0d %0d-%0d-%0d %0d:%0d:%0d, ",
                       what, exp_d.invalid, exp_d.year, exp_d.month, exp_d.day_of_month,
                       exp_d.hour, exp_d.minute, exp_d.second);
                $display("got inv=%0d %0d-%0d-%0d %0d:%0d:%0d",
                         got_d.invalid, got_d.year, got_d.month, got_d.day_of_month,
                         got_d.hour, got_d.minute, got_d.second);
            end
        endfunction

        function void check_date(t_calendar got_d);
            t_calendar exp_d;
            if (pending_dates.size() == 0) begin
                report("Result with no transaction pending", '0, got_d);
                return;
            end
            exp_d = pending_dates.pop_front();
            if (got_d.invalid !== exp_d.invalid || got_d.second !== exp_d.second ||
                got_d.minute !== exp_d.minute || got_d.hour !== exp_d.hour ||
                got_d.day_of_month !== exp_d.day_of_month ||
                got_d.month !== exp_d.month || got_d.year !== exp_d.year)
                report("Date mismatch", exp_d, got_d);
        endfunction

        function int unsigned outstanding();
            return pending_dates.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_epoch_seconds;
    logic               o_strobe;
    logic               o_invalid;
    logic [5:0]         o_second;
    logic [5:0]         o_minute;
    logic [4:0]         o_hour;
    logic [4:0]         o_day_of_month;
    logic [3:0]         o_month;
    logic [10:0]        o_year;

    t_calendar_scoreboard dates;
    int unsigned stamps_taken = 0;
    int unsigned quiet_cycles = 0;

    epoch_seconds_to_calendar_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_epoch_seconds(i_epoch_seconds),
        .o_strobe       (o_strobe),
        .o_invalid      (o_invalid),
        .o_second       (o_second),
        .o_minute       (o_minute),
        .o_hour         (o_hour),
        .o_day_of_month (o_day_of_month),
        .o_month        (o_month),
        .o_year         (o_year)
    );

    always begin
        i_clk = 1'b1;
        #C_PERIOD_HI;
        i_clk = 1'b0;
        #C_PERIOD_LO;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (start && !busy) begin
                dates.note_stamp(i_epoch_seconds);
                stamps_taken <= stamps_taken + 1;
            end
            if (o_strobe === 1'b1) begin
                dates.check_date({o_invalid, o_second, o_minute, o_hour,
                                  o_day_of_month, o_month, o_year});
            end
            if ((start && !busy) || o_strobe === 1'b1) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= C_WATCHDOG_LIMIT) begin
                $display("[epoch_seconds_to_calendar_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic send_stamp(input logic [31:0] stamp, input int unsigned idle_pct);
        int unsigned target;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        target = stamps_taken + 1;
        start <= 1'b1;
        i_epoch_seconds <= stamp;
        do
            @(negedge i_clk);
        while (stamps_taken != target);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (dates.outstanding() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_stamp();
        int unsigned pick;
        longint k;
        pick = $urandom_range(99);
        if (pick < 40) begin
            return $urandom;
        end else if (pick < 65) begin
            k = longint'($urandom_range(49710)) - 24855;
            return 32'(k * 86400 + longint'($urandom_range(4)) - 2);
        end else if (pick < 75) begin
            return 32'($urandom_range(3600)) - 32'd1800;
        end else if (pick < 85) begin
            return 32'h7FFF_FFFF - 32'($urandom_range(200000));
        end else if (pick < 95) begin
            return 32'h8000_0000 + 32'($urandom_range(200000));
        end
        return esc_pkg::C_INVALID_STAMP;
    endfunction

    initial begin
        logic [31:0] directed[$];
        int unsigned idle_plan[4];
        dates = new();
        start = 1'b0;
        i_epoch_seconds = '0;
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0001, 32'h7FFF_FFFE, 32'd1, 32'd59, 32'd60, 32'd3599,
                     32'd86399, 32'd86400, -32'sd86400, -32'sd86401, -32'sd86399,
                     32'd68169600, 32'd68255999, 32'd951782400, 32'd951868800,
                     32'd946684799, 32'd946684800, 32'd1078012800, 32'hFFFF_FFFF,
                     32'd31535999};
        foreach (directed[i])
            send_stamp(directed[i], 0);
        drain_results();

        idle_plan = '{0, 50, 0, 12};
        foreach (idle_plan[p]) begin
            repeat (C_ITEMS_PER_PHASE)
                send_stamp(random_stamp(), idle_plan[p]);
            drain_results();
        end

        repeat (C_DRAIN_CYCLES) @(negedge i_clk);
        if (dates.mismatches == 0 && dates.outstanding() == 0) begin
            $display("[epoch_seconds_to_calendar_unit] OK");
        end else begin
            $display("[epoch_seconds_to_calendar_unit] ERROR");
        end
        $finish;
    end

endmodule
